/* rtl/core/lbp_pkg.sv */
// lbp_pkg: shared sizes, types, codes and helpers for the 3x3 LBP code stream.
// No dependencies; imported by every module of the block but lbp_ram.
package lbp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int POS_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int MODE_W     = 2;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CNT_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W  = (CNT_MAX_W + 1 > SIZE_W) ? CNT_MAX_W + 1 : SIZE_W;

    localparam int WIN_W = 6 * PIX_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(2);

    localparam logic [CODE_W-1:0] NON_UNIFORM_CODE = CODE_W'(170);
    localparam logic [CODE_W-1:0] CODE_ALL_ONES    = CODE_W'(255);

    typedef enum logic [MODE_W-1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_UNIFORM = 2'd1,
        MODE_MIN_ROT = 2'd2
    } code_mode_t;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              restart;
    } frame_cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
    } code_item_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int maxv);
        logic [SIZE_W-1:0] res;
        begin
            if (v < SIZE_W'(3))
                res = SIZE_W'(3);
            else if (int'(v) > maxv)
                res = SIZE_W'(maxv);
            else
                res = v;
            return res;
        end
    endfunction

endpackage

/* rtl/core/lbp_ram.sv */
// lbp_ram: generic single-write, single-read RAM with registered read data.
// Standalone; used for both line buffers.
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/lbp_front.sv */
// lbp_front: pixel intake, frame position, line buffers, 3x3 window and raw code.
// Depends on lbp_pkg and lbp_ram; pushes raw code words into lbp_queue.
module lbp_front
    import lbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  frame_cfg_t        cfg,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  logic [PIX_W-1:0]  gray_pixel,
    input  logic [QCNT_W-1:0] queue_count,
    output logic              push,
    output code_item_t        push_item
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;

    logic [WIN_W-1:0]  window_reg, window_next;

    logic              accept;
    logic              col_wrap;
    logic              row_wrap;
    logic [PIX_W-1:0]  top_pix;
    logic [PIX_W-1:0]  mid_pix;
    logic [PIX_W-1:0]  t1, m1, b1, t2, m2, b2;
    logic [CODE_W-1:0] raw_code;

    assign pixel_ready = ((QCNT_W+1)'(queue_count) + (QCNT_W+1)'(s1_valid_reg))
                         < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept      = pixel_valid && pixel_ready;

    assign col_wrap = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(cfg.width);
    assign row_wrap = (CMP_W'(row_reg) + CMP_W'(1)) >= CMP_W'(cfg.height);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            window_reg   <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            window_reg   <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= gray_pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_emit_reg  <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            s1_last_reg  <= row_wrap && col_wrap;
        end
    end

    // older line holds the row two above, newer line the row just above
    lbp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (mid_pix),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (top_pix)
    );

    lbp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer_line (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (mid_pix)
    );

    assign t1 = window_reg[0*PIX_W +: PIX_W];
    assign m1 = window_reg[1*PIX_W +: PIX_W];
    assign b1 = window_reg[2*PIX_W +: PIX_W];
    assign t2 = window_reg[3*PIX_W +: PIX_W];
    assign m2 = window_reg[4*PIX_W +: PIX_W];
    assign b2 = window_reg[5*PIX_W +: PIX_W];

    always_comb
    begin
        window_next = window_reg;
        if (cfg.restart)
        begin
            window_next = '0;
        end
        else if (s1_valid_reg)
        begin
            window_next = {window_reg[3*PIX_W-1:0], s1_pixel_reg, mid_pix, top_pix};
        end
    end

    // centre is the middle pixel of the previous column
    assign raw_code = {t2 > m1, t1 > m1, top_pix > m1, mid_pix > m1,
                       s1_pixel_reg > m1, b1 > m1, b2 > m1, m2 > m1};

    assign push           = s1_valid_reg && s1_emit_reg;
    assign push_item.code = raw_code;
    assign push_item.row  = POS_W'(s1_row_reg - ROW_W'(1));
    assign push_item.col  = POS_W'(s1_col_reg - COL_W'(1));
    assign push_item.last = s1_last_reg;

endmodule

/* rtl/core/lbp_queue.sv */
// lbp_queue: short register FIFO of raw code words between front and back.
// Depends on lbp_pkg.
module lbp_queue
    import lbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  code_item_t        push_item,
    input  logic              pop,
    output code_item_t        head_item,
    output logic              not_empty,
    output logic [QCNT_W-1:0] count
);

    code_item_t        item_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item = item_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

endmodule

/* rtl/core/lbp_back.sv */
// lbp_back: mode mapping of raw codes and the output word register.
// Depends on lbp_pkg; drains lbp_queue.
module lbp_back
    import lbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MODE_W-1:0] mode,
    input  code_item_t        head_item,
    input  logic              not_empty,
    output logic              pop,
    output logic              code_valid,
    input  logic              code_ready,
    output logic [CODE_W-1:0] pattern_code,
    output logic [POS_W-1:0]  center_row,
    output logic [POS_W-1:0]  center_col,
    output logic              last_of_frame
);

    logic              out_valid_reg;
    code_item_t        out_item_reg;
    logic [CODE_W-1:0] rot   [CODE_W];
    logic [CODE_W-1:0] uniform_code;
    logic [CODE_W-1:0] min_code;
    logic [CODE_W-1:0] mapped_code;

    // rot[i] is the code rotated left by i+1
    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
        begin
            rot[i] = CODE_W'({head_item.code, head_item.code} >> (CODE_W - 1 - i));
        end
    end

    always_comb
    begin
        uniform_code = NON_UNIFORM_CODE;
        for (int i = CODE_W - 1; i >= 0; i--)
        begin
            if ((((CODE_W+1)'(rot[i]) + (CODE_W+1)'(1)) & (CODE_W+1)'(rot[i])) == '0)
                uniform_code = rot[i];
        end
    end

    always_comb
    begin
        min_code = CODE_ALL_ONES;
        for (int i = 0; i < CODE_W; i++)
        begin
            if (rot[i] < min_code)
                min_code = rot[i];
        end
    end

    always_comb
    begin
        case (mode)
            MODE_UNIFORM: mapped_code = uniform_code;
            MODE_MIN_ROT: mapped_code = min_code;
            MODE_PLAIN:   mapped_code = head_item.code;
            default:      mapped_code = head_item.code;
        endcase
    end

    assign pop = not_empty && (!out_valid_reg || code_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (code_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg.code <= mapped_code;
            out_item_reg.row  <= head_item.row;
            out_item_reg.col  <= head_item.col;
            out_item_reg.last <= head_item.last;
        end
    end

    assign code_valid    = out_valid_reg;
    assign pattern_code  = out_item_reg.code;
    assign center_row    = out_item_reg.row;
    assign center_col    = out_item_reg.col;
    assign last_of_frame = out_item_reg.last;

endmodule

/* rtl/core/lbp_3x3_code_stream.sv */
// lbp_3x3_code_stream: top level of the 3x3 local binary pattern code stream.
// Depends on lbp_pkg, lbp_front, lbp_queue and lbp_back.
//
// Takes one 8-bit grayscale pixel per clock in raster order, while the queue
// has room, and gives one 8-bit pattern code per interior pixel, with its
// row, column and an end of frame flag; border pixels give no word. Sustained
// rate is one pixel per clock while the output keeps up, set by the single
// read port per line buffer RAM. Once its last pixel is taken, a code word
// passes the line buffer read, the window compare into a four-word queue and
// the mode mapping into the output register. The queue lets pixel intake run
// on while the output is stalled until four words wait. Line buffers need no
// clearing after reset. Writing width or height restarts the frame at row 0,
// column 0; registers are to be written only while no word is in flight.
module lbp_3x3_code_stream
    import lbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  logic [PIX_W-1:0]      gray_pixel,
    output logic                  code_valid,
    input  logic                  code_ready,
    output logic [CODE_W-1:0]     pattern_code,
    output logic [POS_W-1:0]      center_row,
    output logic [POS_W-1:0]      center_col,
    output logic                  last_of_frame
);

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [MODE_W-1:0] mode_reg;

    logic              cfg_fire;
    frame_cfg_t        frame_cfg;
    logic              q_push;
    code_item_t        q_push_item;
    logic              q_pop;
    code_item_t        q_head;
    logic              q_not_empty;
    logic [QCNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // sizes are held already saturated to the supported range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(WIDTH_RESET);
            height_reg <= SIZE_W'(HEIGHT_RESET);
            mode_reg   <= MODE_PLAIN;
        end
        else if (cfg_fire)
        begin
            if (cfg_index == REG_WIDTH)
                width_reg <= clamp_size(SIZE_W'(cfg_data), MAX_WIDTH);
            if (cfg_index == REG_HEIGHT)
                height_reg <= clamp_size(SIZE_W'(cfg_data), MAX_HEIGHT);
            if (cfg_index == REG_MODE)
                mode_reg <= cfg_data[MODE_W-1:0];
        end
    end

    assign frame_cfg.width   = width_reg;
    assign frame_cfg.height  = height_reg;
    assign frame_cfg.restart = cfg_fire && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    lbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (frame_cfg),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .gray_pixel  (gray_pixel),
        .queue_count (q_count),
        .push        (q_push),
        .push_item   (q_push_item)
    );

    lbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head_item (q_head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    lbp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode_reg),
        .head_item     (q_head),
        .not_empty     (q_not_empty),
        .pop           (q_pop),
        .code_valid    (code_valid),
        .code_ready    (code_ready),
        .pattern_code  (pattern_code),
        .center_row    (center_row),
        .center_col    (center_col),
        .last_of_frame (last_of_frame)
    );

    // a word is never pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("code queue overflow");

    // a word is never popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_count != '0))
        else $error("code queue underflow");

    // intake must leave room for the word still in the compare stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_ready) |=> (q_count < QCNT_W'(QUEUE_DEPTH)) || !q_push)
        else $error("pixel taken without queue room");

endmodule

/* tb/sv/lbp_3x3_code_stream_tb.sv */
// Self-checking testbench for lbp_3x3_code_stream: raster pixel frames in,
// pattern code words checked against an in-bench window and line predictor.
// Depends on lbp_pkg and the lbp_3x3_code_stream RTL.
`timescale 1ns / 100ps

module lbp_3x3_code_stream_tb;
    import lbp_pkg::*;

    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned END_CYCLES     = 16;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned RANDOM_ITEMS   = 400;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = CFG_IDX_W'(3);
    localparam logic [MODE_W-1:0]    MODE_SPARE = MODE_W'(3);

    localparam logic [PIX_W-1:0] DIRECTED_PIXELS [27] = '{
        8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
        8'd200, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100,
        8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0
    };
    localparam logic [MODE_W-1:0] DIRECTED_MODES [3] = '{MODE_PLAIN, MODE_UNIFORM,
                                                        MODE_MIN_ROT};

    // extreme sizes: both clamped low, height clamped high, width clamped high and height low
    localparam logic [CFG_DATA_W-1:0] BIG_WIDTHS  [3] = '{11'd0, 11'd3, 11'd2047};
    localparam logic [CFG_DATA_W-1:0] BIG_HEIGHTS [3] = '{11'd2, 11'd2047, 11'd1};
    localparam logic [MODE_W-1:0]     BIG_MODES   [3] = '{MODE_UNIFORM, MODE_MIN_ROT,
                                                         MODE_SPARE};
    localparam int unsigned           BIG_COUNTS  [3] = '{27, 60, 40};

    typedef enum {PIX_ANY, PIX_NARROW, PIX_EXTREME} pix_flavour_t;
    typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STARVED} rx_style_t;

    class lbp_window_tracker;
        bit   [PIX_W-1:0]  upper_row [MAX_WIDTH];
        bit   [PIX_W-1:0]  middle_row [MAX_WIDTH];
        bit   [WIN_W-1:0]  taps;
        int unsigned       row_at;
        int unsigned       col_at;
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        logic [MODE_W-1:0] mode_reg;
        code_item_t        awaited_codes [$];
        int unsigned       fails;

        function new();
            taps       = '0;
            row_at     = 0;
            col_at     = 0;
            width_reg  = SIZE_W'(WIDTH_RESET);
            height_reg = SIZE_W'(HEIGHT_RESET);
            mode_reg   = MODE_PLAIN;
            fails      = 0;
        endfunction

        static function int unsigned span(logic [SIZE_W-1:0] v, int unsigned top);
            if (v < 3)
                return 3;
            if (v > top)
                return top;
            return v;
        endfunction

        function logic [CODE_W-1:0] remap(logic [CODE_W-1:0] raw);
            logic [CODE_W-1:0] r;
            logic [CODE_W-1:0] lowest;
            r = raw;
            lowest = CODE_ALL_ONES;
            if (mode_reg == MODE_UNIFORM)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    r = {r[CODE_W-2:0], r[CODE_W-1]};
                    if ((({1'b0, r} + 9'd1) & {1'b0, r}) == 9'd0)
                        return r;
                end
                return NON_UNIFORM_CODE;
            end
            if (mode_reg == MODE_MIN_ROT)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    r = {r[CODE_W-2:0], r[CODE_W-1]};
                    if (r < lowest)
                        lowest = r;
                end
                return lowest;
            end
            return raw;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_WIDTH, REG_HEIGHT:
                begin
                    if (idx == REG_WIDTH)
                        width_reg = value;
                    else
                        height_reg = value;
                    row_at = 0;
                    col_at = 0;
                    taps   = '0;
                end
                REG_MODE:
                    mode_reg = value[MODE_W-1:0];
                default:
                    ;
            endcase
        endfunction

        function void take_pixel(logic [PIX_W-1:0] below);
            int unsigned      w;
            int unsigned      h;
            logic [PIX_W-1:0] above;
            logic [PIX_W-1:0] beside;
            logic [PIX_W-1:0] t1, m1, b1, t2, m2, b2;
            logic [CODE_W-1:0] raw;
            code_item_t       item;
            w = span(width_reg, MAX_WIDTH);
            h = span(height_reg, MAX_HEIGHT);
            above  = upper_row[col_at];
            beside = middle_row[col_at];
            {b2, m2, t2, b1, m1, t1} = taps;
            if (row_at >= 2 && col_at >= 2)
            begin
                raw = {t2 > m1, t1 > m1, above > m1, beside > m1,
                       below > m1, b1 > m1, b2 > m1, m2 > m1};
                item.code = remap(raw);
                item.row  = POS_W'(row_at - 1);
                item.col  = POS_W'(col_at - 1);
                item.last = (row_at + 1 >= h) && (col_at + 1 >= w);
                awaited_codes.push_back(item);
            end
            upper_row[col_at]  = beside;
            middle_row[col_at] = below;
            taps = {taps[WIN_W-25:0], below, beside, above};
            if (col_at + 1 >= w)
            begin
                col_at = 0;
                row_at = (row_at + 1 >= h) ? 0 : row_at + 1;
            end
            else
                col_at++;
        endfunction

        function void check_code(code_item_t got);
            code_item_t want;
            if (awaited_codes.size() == 0)
            begin
                $error("unexpected code word: code %0d row %0d col %0d last %0d",
                       got.code, got.row, got.col, got.last);
                fails++;
                return;
            end
            want = awaited_codes.pop_front();
            if (got.code !== want.code)
            begin
                $error("pattern_code: expected %0d, got %0d", want.code, got.code);
                fails++;
            end
            if (got.row !== want.row)
            begin
                $error("center_row: expected %0d, got %0d", want.row, got.row);
                fails++;
            end
            if (got.col !== want.col)
            begin
                $error("center_col: expected %0d, got %0d", want.col, got.col);
                fails++;
            end
            if (got.last !== want.last)
            begin
                $error("last_of_frame: expected %0d, got %0d", want.last, got.last);
                fails++;
            end
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  pixel_valid   = 1'b0;
    logic                  pixel_ready;
    logic [PIX_W-1:0]      gray_pixel    = '0;
    logic                  code_valid;
    logic                  code_ready    = 1'b0;
    logic [CODE_W-1:0]     pattern_code;
    logic [POS_W-1:0]      center_row;
    logic [POS_W-1:0]      center_col;
    logic                  last_of_frame;

    lbp_window_tracker tracker;
    bit                long_hold_req = 1'b0;
    bit                sender_steady = 1'b0;
    int unsigned       burst_left    = 0;
    int unsigned       quiet_cycles  = 0;

    lbp_3x3_code_stream dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .gray_pixel    (gray_pixel),
        .code_valid    (code_valid),
        .code_ready    (code_ready),
        .pattern_code  (pattern_code),
        .center_row    (center_row),
        .center_col    (center_col),
        .last_of_frame (last_of_frame)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // handshake monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (code_valid && code_ready)
                tracker.check_code(code_item_t'({pattern_code, center_row, center_col,
                                                 last_of_frame}));
            if (cfg_valid && cfg_ready)
                tracker.set_register(cfg_index, cfg_data);
            if (pixel_valid && pixel_ready)
                tracker.take_pixel(gray_pixel);
            if ((code_valid && code_ready) || (cfg_valid && cfg_ready)
                || (pixel_valid && pixel_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // code word receiver
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned style_left;
        rx_style_t   style;
        hold_left  = 0;
        style_left = 0;
        style      = RX_OPEN;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                code_ready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style = rx_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(16, 96);
                end
                style_left--;
                case (style)
                    RX_OPEN:     code_ready <= 1'b1;
                    RX_COIN:     code_ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: code_ready <= (style_left % 4) != 0;
                    default:     code_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        logic [CFG_DATA_W-MODE_W-1:0] pad;
        pad = (CFG_DATA_W-MODE_W)'($urandom);
        write_reg(REG_MODE, {pad, mode});
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int unsigned gap;
        if (!sender_steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                pixel_valid <= 1'b0;
            end
        end
        if (burst_left != 0)
            burst_left--;
        @(negedge clk);
        pixel_valid <= 1'b1;
        gray_pixel  <= value;
        do @(posedge clk); while (!pixel_ready);
    endtask

    task automatic send_run(input int unsigned count, input pix_flavour_t flavour);
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] value;
        base = PIX_W'($urandom);
        for (int unsigned n = 0; n < count; n++)
        begin
            case (flavour)
                PIX_NARROW:  value = base + PIX_W'($urandom_range(0, 2));
                PIX_EXTREME: value = $urandom_range(0, 1) ? '1 : '0;
                default:     value = PIX_W'($urandom);
            endcase
            send_pixel(value);
        end
    endtask

    // wait out every awaited word plus the pipeline depth
    task automatic settle();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (tracker.awaited_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned           frame_px;
        int unsigned           count;
        int unsigned           sent;
        int unsigned           phase;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        tracker  = new();
        frame_px = 9;
        sent     = 0;
        phase    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed 3x3 frames: all above centre, single bit, ties at 100 and at 0
        write_reg(REG_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_HEIGHT, CFG_DATA_W'(3));
        for (int f = 0; f < 3; f++)
        begin
            write_mode(DIRECTED_MODES[f]);
            for (int p = 0; p < 9; p++)
                send_pixel(DIRECTED_PIXELS[f * 9 + p]);
            settle();
        end

        for (int s = 0; s < 3; s++)
        begin
            write_reg(REG_WIDTH, BIG_WIDTHS[s]);
            write_reg(REG_HEIGHT, BIG_HEIGHTS[s]);
            write_mode(BIG_MODES[s]);
            if (s == 1)
                long_hold_req = 1'b1;
            send_run(BIG_COUNTS[s], PIX_ANY);
            settle();
        end

        while (sent < RANDOM_ITEMS)
        begin
            phase++;
            if (phase == 1 || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       w_data = CFG_DATA_W'($urandom_range(0, 2));
                    1:       w_data = CFG_DATA_W'($urandom_range(13, 24));
                    default: w_data = CFG_DATA_W'($urandom_range(3, 8));
                endcase
                if ($urandom_range(0, 7) == 0)
                    h_data = CFG_DATA_W'($urandom_range(0, 2));
                else
                    h_data = CFG_DATA_W'($urandom_range(3, 6));
                write_reg(REG_WIDTH, w_data);
                write_reg(REG_HEIGHT, h_data);
                frame_px = ((w_data < 3) ? 3 : w_data) * ((h_data < 3) ? 3 : h_data);
            end
            if ($urandom_range(0, 3) != 0)
                write_mode(MODE_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, CFG_DATA_W'($urandom));
            sender_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, frame_px + 8);
            else
                count = frame_px * $urandom_range(1, 2);
            if (phase == 3)
                long_hold_req = 1'b1;
            send_run(count, pix_flavour_t'($urandom_range(0, 2)));
            settle();
            sent += count;
        end

        repeat (END_CYCLES) @(posedge clk);
        if (tracker.fails == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
